// ===== rtl/clnws_pkg.sv =====
// Shared types, codes and constants for the character-LCD nibble write sequencer.
// Used by the front classifier, the item queue, the pin-state back end and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package clnws_pkg;

  // Input operation codes
  localparam logic [1:0] CMD_WRITE_COMMAND = 2'd0;
  localparam logic [1:0] CMD_WRITE_CHAR    = 2'd1;
  localparam logic [1:0] CMD_MOVE_CURSOR   = 2'd2;

  localparam int unsigned HOLD_W = 10;
  localparam logic [HOLD_W-1:0] WAIT_RESET_US = 10'd800;
  localparam logic [HOLD_W-1:0] NIBBLE_HOLD_US = 10'd3;
  localparam logic [7:0] HIGH_NIBBLE_MASK = 8'hF0;
  localparam logic [7:0] LOW_NIBBLE_MASK  = 8'h0F;
  localparam logic [7:0] SET_DDRAM_ADDR   = 8'h80;

  // Pin-state phases of one transaction; the wait phase only precedes
  // the first character after a command.
  localparam logic [2:0] PH_WAIT     = 3'd0;
  localparam logic [2:0] PH_SETUP    = 3'd1;
  localparam logic [2:0] PH_EN_OLD   = 3'd2;
  localparam logic [2:0] PH_EN_HI    = 3'd3;
  localparam logic [2:0] PH_LATCH_HI = 3'd4;
  localparam logic [2:0] PH_EN_HI2   = 3'd5;
  localparam logic [2:0] PH_EN_LO    = 3'd6;
  localparam logic [2:0] PH_LATCH_LO = 3'd7;

  // One classified item between front and back
  typedef struct packed {
    logic              rs;
    logic [7:0]        data_byte;
    logic [3:0]        old_nibble;
    logic              old_rs;
    logic              with_wait;
    logic [HOLD_W-1:0] wait_us;
  } clnws_item_t;

  function automatic logic [7:0] row_offset(input logic [1:0] r);
    logic [7:0] o;
    case (r)
      2'd0: o = 8'h00;
      2'd1: o = 8'h40;
      2'd2: o = 8'h10;
      default: o = 8'h50;
    endcase
    return o;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/clnws_front.sv =====
// Front end: accepts input items, classifies them and tracks the display line state.
// Holds the post-command wait register. Depends on clnws_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clnws_front (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire  [1:0]           cmd,
  input  wire  [7:0]           value,
  input  wire  [1:0]           row,
  input  wire  [3:0]           col,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire  [9:0]           cfg_data,
  output logic                 push,
  output clnws_pkg::clnws_item_t push_item,
  input  wire                  queue_full
);
  import clnws_pkg::*;

  logic [HOLD_W-1:0] wait_us;
  logic              command_pending;
  logic [3:0]        bus_level;
  logic              select_level;
  logic              accept;
  logic              is_write;
  logic [7:0]        cursor_addr;

  assign in_ready  = !queue_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign cursor_addr = (8'(col) + row_offset(row)) | SET_DDRAM_ADDR;

  always_comb begin
    is_write            = 1'b1;
    push_item.rs        = 1'b0;
    push_item.data_byte = value;
    push_item.with_wait = 1'b0;
    case (cmd)
      CMD_WRITE_COMMAND: begin
        push_item.rs = 1'b0;
      end
      CMD_WRITE_CHAR: begin
        push_item.rs        = 1'b1;
        push_item.with_wait = command_pending;
      end
      CMD_MOVE_CURSOR: begin
        push_item.data_byte = cursor_addr;
      end
      default: begin
        is_write = 1'b0;
      end
    endcase
    push_item.old_nibble = bus_level;
    push_item.old_rs     = select_level;
    push_item.wait_us    = wait_us;
  end

  assign push = accept && is_write;

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_us         <= WAIT_RESET_US;
      command_pending <= 1'b0;
      bus_level       <= 4'd0;
      select_level    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        wait_us <= cfg_data;
      end
      if (push) begin
        command_pending <= !push_item.rs;
        bus_level       <= push_item.data_byte[3:0];
        select_level    <= push_item.rs;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/clnws_queue.sv =====
// Two-entry queue of classified items between front and back end.
// Depends on clnws_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clnws_queue (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   push,
  input  clnws_pkg::clnws_item_t push_item,
  output logic                  full,
  input  wire                   pop,
  output logic                  not_empty,
  output clnws_pkg::clnws_item_t head
);
  import clnws_pkg::*;

  clnws_item_t slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        do_pop;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = slots[rd_ptr];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      case ({push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/clnws_back.sv =====
// Back end: walks each item's pin states, one per unstalled cycle, into an output register.
// Depends on clnws_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clnws_back (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   not_empty,
  input  clnws_pkg::clnws_item_t head,
  output logic                  pop,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic                  reg_select,
  output logic                  enable,
  output logic [3:0]            bus_nibble,
  output logic [9:0]            hold_us,
  output logic                  last
);
  import clnws_pkg::*;

  logic [2:0]        step;
  logic [2:0]        phase;
  logic              load;
  logic              is_last;
  logic              rs_n;
  logic              en_n;
  logic [3:0]        nib_n;
  logic [HOLD_W-1:0] hold_n;
  logic [HOLD_W-1:0] edge_hold;
  logic [3:0]        hi;
  logic [3:0]        lo;

  assign load    = not_empty && (!out_valid || out_ready);
  assign phase   = step + {2'b00, !head.with_wait};
  assign is_last = (phase == PH_LATCH_LO);
  assign pop     = load && is_last;
  assign hi      = 4'((head.data_byte & HIGH_NIBBLE_MASK) >> 4);
  assign lo      = 4'(head.data_byte & LOW_NIBBLE_MASK);
  assign edge_hold = {{(HOLD_W-1){1'b0}}, head.rs};

  always_comb begin
    rs_n   = head.rs;
    en_n   = 1'b0;
    nib_n  = head.old_nibble;
    hold_n = NIBBLE_HOLD_US;
    unique case (phase)
      PH_WAIT: begin
        rs_n   = head.old_rs;
        hold_n = head.wait_us;
      end
      PH_SETUP:    hold_n = edge_hold;
      PH_EN_OLD: begin
        en_n   = 1'b1;
        hold_n = edge_hold;
      end
      PH_EN_HI: begin
        en_n  = 1'b1;
        nib_n = hi;
      end
      PH_LATCH_HI: nib_n = hi;
      PH_EN_HI2: begin
        en_n  = 1'b1;
        nib_n = hi;
      end
      PH_EN_LO: begin
        en_n  = 1'b1;
        nib_n = lo;
      end
      PH_LATCH_LO: begin
        nib_n  = lo;
        hold_n = edge_hold;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        step      <= is_last ? 3'd0 : step + 3'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      reg_select <= rs_n;
      enable     <= en_n;
      bus_nibble <= nib_n;
      hold_us    <= hold_n;
      last       <= is_last;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/char_lcd_nibble_write_sequencer_core.sv =====
// Top level of the character-LCD 4-bit write sequencer.
// Instantiates clnws_front, clnws_queue and clnws_back; depends on clnws_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   Input channel (in_valid/in_ready, cmd/value/row/col) takes one transaction
//   per operation: write command byte, write character, or move cursor to a
//   row/column. Unused cmd code 3 is accepted and dropped with no output.
//   Output channel (out_valid/out_ready) delivers pin states: reg_select,
//   enable, bus_nibble and hold_us, with last set on the final state of a
//   transaction. A command or cursor move yields 7 states; a character
//   yields 7, or 8 when it is the first character after a command (a leading
//   wait state held for the configured post-command wait).
//   Configuration channel (cfg_valid/cfg_ready, cfg_data) writes the 10-bit
//   post-command wait in microseconds; cfg_ready is always high.
//   Path: the item enters the queue at the accepting edge, and the output
//   register then loads its first pin state from the queue head.
//   The back end emits one pin state per cycle while the receiver keeps
//   out_ready high. The two-entry queue lets the front accept new
//   transactions while the back end is still busy.
//   When the receiver stalls, the output register holds its state and the
//   back end freezes; the front keeps accepting until the queue fills.
//   Reset (rst, synchronous) empties the queue, clears the pending-command
//   flag and the tracked bus and select levels, and sets the wait to 800 us.

module char_lcd_nibble_write_sequencer_core (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire  [1:0] cmd,
  input  wire  [7:0] value,
  input  wire  [1:0] row,
  input  wire  [3:0] col,
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire  [9:0] cfg_data,
  output logic       out_valid,
  input  wire        out_ready,
  output logic       reg_select,
  output logic       enable,
  output logic [3:0] bus_nibble,
  output logic [9:0] hold_us,
  output logic       last
);
  import clnws_pkg::*;

  logic        push;
  clnws_item_t push_item;
  logic        queue_full;
  logic        pop;
  logic        not_empty;
  clnws_item_t head;

  // Classify and track display state
  clnws_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .value      (value),
    .row        (row),
    .col        (col),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .push       (push),
    .push_item  (push_item),
    .queue_full (queue_full)
  );

  // Decouple front and back
  clnws_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  // Expand each item into pin states
  clnws_back u_back (
    .clk        (clk),
    .rst        (rst),
    .not_empty  (not_empty),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .reg_select (reg_select),
    .enable     (enable),
    .bus_nibble (bus_nibble),
    .hold_us    (hold_us),
    .last       (last)
  );

endmodule

`default_nettype wire
